// File: hw/rtl/lae_pkg.sv
// shared constants, types and codes for the life automaton engine
`default_nettype none

package lae_pkg;

  // grid bounds
  localparam int MAX_COLS = 32;
  localparam int MAX_ROWS = 32;

  // derived widths
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int STEP_W    = $clog2(MAX_ROWS + 2);

  // fixed field widths
  localparam int CFG_W  = 6;
  localparam int X_W    = 5;
  localparam int Y_W    = 5;
  localparam int ACT_W  = 2;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int NBR_W  = 4;

  // compare widths for coordinate range checks
  localparam int XC_W = (X_W > COL_CNT_W) ? X_W : COL_CNT_W;
  localparam int YC_W = (Y_W > ROW_CNT_W) ? Y_W : ROW_CNT_W;

  // last step of a generation sweep
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_ROWS + 1);

  // register reset values
  localparam logic [CFG_W-1:0] COLS_RESET = CFG_W'(30);
  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(30);

  // B3/S23 neighbor counts
  localparam logic [NBR_W-1:0] LIFE_BIRTH = NBR_W'(3);
  localparam logic [NBR_W-1:0] LIFE_STAY  = NBR_W'(2);

  // action codes (the unused code behaves as a read)
  localparam logic [ACT_W-1:0] ACT_SET     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;

  // register index codes (byte address bit 2)
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef logic [MAX_COLS-1:0] row_t;

endpackage

`default_nettype wire

// File: hw/rtl/lae_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module lae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/lae_row_rule.sv
// next-generation rule for one row from a three-row window
`default_nettype none

module lae_row_rule (
  input  wire lae_pkg::row_t up,
  input  wire lae_pkg::row_t mid,
  input  wire lae_pkg::row_t dn,
  input  wire lae_pkg::row_t col_mask,
  input  wire logic          row_live,
  output lae_pkg::row_t      next_row
);
  import lae_pkg::*;

  // rows padded with a dead cell on each side
  logic [MAX_COLS+1:0] up_p;
  logic [MAX_COLS+1:0] mid_p;
  logic [MAX_COLS+1:0] dn_p;

  assign up_p  = {1'b0, up, 1'b0};
  assign mid_p = {1'b0, mid, 1'b0};
  assign dn_p  = {1'b0, dn, 1'b0};

  // per-cell neighbor count and rule
  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    logic [NBR_W-1:0] nbr;

    assign nbr = NBR_W'(up_p[i]) + NBR_W'(up_p[i+1]) + NBR_W'(up_p[i+2])
               + NBR_W'(mid_p[i]) + NBR_W'(mid_p[i+2])
               + NBR_W'(dn_p[i]) + NBR_W'(dn_p[i+1]) + NBR_W'(dn_p[i+2]);

    assign next_row[i] = col_mask[i] & row_live
                       & ((nbr == LIFE_BIRTH) | (mid[i] & (nbr == LIFE_STAY)));
  end

endmodule

`default_nettype wire

// File: hw/rtl/life_automaton_engine.sv
// life automaton engine top level: control, grid memory and config registers
// set/read: S_LOOKUP (skipped if the coordinate is flagged), then S_FINISH to the output register
// advance: sweep through the grid ram, one row read and one row written per cycle,
//   then S_FINISH to the output register
// one word at a time: in_stall is high outside S_IDLE; one ram read port sets the sweep
// reset: synchronous, clears control state and row valid bits (grid reads as all dead)
`default_nettype none

module life_automaton_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lae_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [lae_pkg::DATA_W-1:0]    pwdata,
  output logic      [lae_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lae_pkg::ACT_W-1:0]     action,
  input  wire logic [lae_pkg::X_W-1:0]       cell_x,
  input  wire logic [lae_pkg::Y_W-1:0]       cell_y,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               cell_alive,
  output logic                               status
);
  import lae_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_LOOKUP = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state;

  logic [CFG_W-1:0]     active_cols;
  logic [CFG_W-1:0]     active_rows;
  logic [COL_CNT_W-1:0] eff_cols;
  logic [ROW_CNT_W-1:0] eff_rows;
  row_t                 col_mask;

  logic [STEP_W-1:0]    step;
  logic [STEP_W-1:0]    wr_step;
  row_t                 win_up;
  row_t                 win_mid;
  row_t                 sweep_in;
  row_t                 rule_row;
  logic                 rule_live;

  logic [MAX_ROWS-1:0]  row_valid;
  logic                 rd_live;
  logic                 rd_ok;
  row_t                 rd_data;
  row_t                 lookup_row;

  logic                 req_set;
  logic [COL_W-1:0]     req_x;
  logic [ROW_W-1:0]     req_y;
  logic                 res_alive;
  logic                 res_status;

  logic                 in_accept;
  logic                 in_range;
  logic                 cfg_wr;
  logic                 out_free;

  logic                 rd_en;
  logic [ROW_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [ROW_W-1:0]     wr_addr;
  row_t                 wr_data;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_cols <= COLS_RESET;
      active_rows <= ROWS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_COLS: active_cols <= pwdata[CFG_W-1:0];
        REG_ROWS: active_rows <= pwdata[CFG_W-1:0];
        default:  active_cols <= active_cols;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COLS: prdata = DATA_W'(active_cols);
      REG_ROWS: prdata = DATA_W'(active_rows);
      default:  prdata = '0;
    endcase
  end

  // active grid, clamped to the grid bounds
  assign eff_cols = (active_cols > MAX_COLS) ? COL_CNT_W'(MAX_COLS) : COL_CNT_W'(active_cols);
  assign eff_rows = (active_rows > MAX_ROWS) ? ROW_CNT_W'(MAX_ROWS) : ROW_CNT_W'(active_rows);

  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      col_mask[i] = (COL_CNT_W'(i) < eff_cols);
    end
  end

  // input handshake and coordinate check
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign in_range  = (XC_W'(cell_x) < XC_W'(eff_cols)) & (YC_W'(cell_y) < YC_W'(eff_rows));
  assign out_free  = ~out_valid | ~out_stall;

  // sweep window: incoming row is the one below the row being rewritten
  assign sweep_in   = rd_live ? (rd_data & col_mask) : '0;
  assign lookup_row = rd_live ? rd_data : '0;
  assign wr_step    = step - STEP_W'(2);
  assign rule_live  = (YC_W'(wr_step) < YC_W'(eff_rows));

  lae_row_rule u_rule (
    .up       (win_up),
    .mid      (win_mid),
    .dn       (sweep_in),
    .col_mask (col_mask),
    .row_live (rule_live),
    .next_row (rule_row)
  );

  // memory port control; rows are rewritten in place at wr_step, behind the read
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ROW_W'(cell_y);
    rd_ok   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = req_y;
    wr_data = rule_row;
    unique case (state)
      S_IDLE: begin
        rd_en   = in_accept;
        rd_addr = ROW_W'(cell_y);
        rd_ok   = row_valid[rd_addr];
      end
      S_SWEEP: begin
        rd_en   = (step < STEP_W'(MAX_ROWS));
        rd_addr = step[ROW_W-1:0];
        rd_ok   = row_valid[rd_addr] & (YC_W'(step) < YC_W'(eff_rows));
        wr_en   = (step >= STEP_W'(2));
        wr_addr = wr_step[ROW_W-1:0];
        wr_data = rule_row;
      end
      S_LOOKUP: begin
        wr_en   = req_set;
        wr_addr = req_y;
        wr_data = lookup_row | (row_t'(1) << req_x);
      end
      S_FINISH: begin
        rd_en = 1'b0;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  lae_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // row valid bits: an unwritten row reads as all dead
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_live   <= 1'b0;
    end else begin
      rd_live <= rd_en & rd_ok;
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (action == ACT_ADVANCE) begin
              state <= S_SWEEP;
              step  <= '0;
            end else if (in_range) begin
              state <= S_LOOKUP;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SWEEP: begin
          step <= step + STEP_W'(1);
          if (step == STEP_LAST) begin
            state <= S_FINISH;
          end
        end
        S_LOOKUP: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request, window and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        req_set    <= (action == ACT_SET);
        req_x      <= COL_W'(cell_x);
        req_y      <= ROW_W'(cell_y);
        win_up     <= '0;
        win_mid    <= '0;
        res_alive  <= 1'b0;
        res_status <= ~in_range;
      end
      S_SWEEP: begin
        if (step != '0) begin
          win_up  <= win_mid;
          win_mid <= sweep_in;
        end
        res_alive  <= 1'b0;
        res_status <= 1'b0;
      end
      S_LOOKUP: begin
        res_alive  <= req_set | lookup_row[req_x];
        res_status <= 1'b0;
      end
      S_FINISH: begin
        res_alive <= res_alive;
      end
      default: begin
        res_alive <= res_alive;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      cell_alive <= res_alive;
      status     <= res_status;
    end
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("grid ram read and write hit the same row");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && step == STEP_LAST) |=>
      (state == S_FINISH && (&row_valid) && !res_alive && !res_status))
    else $error("generation sweep did not finish cleanly");

  a_set_alive: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOKUP && req_set) |=> res_alive)
    else $error("set cell did not report alive");

  a_flag_dead: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> !cell_alive)
    else $error("flagged word reports a live cell");

endmodule

`default_nettype wire

// File: tb/life_automaton_engine_tb.sv
// self-checking testbench for the life automaton engine: grid set, read and generation advance
`timescale 1ns / 100ps

module life_automaton_engine_tb;
  import lae_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_MAX = 10;
  // spare action code, handled as a read
  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
  } cell_word_t;

  typedef struct packed {
    logic alive;
    logic flag;
  } cell_result_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [ACT_W-1:0]  action;
  logic [X_W-1:0]    cell_x;
  logic [Y_W-1:0]    cell_y;
  logic              out_valid;
  logic              out_stall;
  logic              cell_alive;
  logic              status;

  // predictor state: grid copy and register copies
  row_t             life_grid [MAX_ROWS];
  logic [CFG_W-1:0] grid_cols;
  logic [CFG_W-1:0] grid_rows;

  cell_word_t   pending_words [$];
  cell_result_t expected_cells [$];
  bit           in_fire;
  int           send_idle;
  int           recv_idle;
  int           mismatch_count;
  int           cycle_count;

  life_automaton_engine dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .cell_x    (cell_x),
    .cell_y    (cell_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_alive(cell_alive),
    .status    (status)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int active_cols();
    return (int'(grid_cols) > MAX_COLS) ? MAX_COLS : int'(grid_cols);
  endfunction

  function automatic int active_rows();
    return (int'(grid_rows) > MAX_ROWS) ? MAX_ROWS : int'(grid_rows);
  endfunction

  // cells off the active grid count as dead
  function automatic int cell_at(row_t row, int x, int cols);
    if (x < 0 || x >= cols)
      return 0;
    return int'(row[x]);
  endfunction

  // one B3/S23 generation over the active rectangle, everything else cleared
  function automatic void life_generation();
    int   cols;
    int   rows;
    int   n;
    row_t m;
    row_t up;
    row_t mid;
    row_t dn;
    row_t nxt [MAX_ROWS];
    cols = active_cols();
    rows = active_rows();
    m = (cols >= MAX_COLS) ? '1 : row_t'((64'd1 << cols) - 64'd1);
    for (int y = 0; y < MAX_ROWS; y++)
      nxt[y] = '0;
    for (int y = 0; y < rows; y++) begin
      up  = (y > 0) ? (life_grid[y-1] & m) : '0;
      mid = life_grid[y] & m;
      dn  = (y + 1 < rows) ? (life_grid[y+1] & m) : '0;
      for (int x = 0; x < cols; x++) begin
        n = cell_at(up, x - 1, cols) + cell_at(up, x, cols) + cell_at(up, x + 1, cols)
          + cell_at(mid, x - 1, cols) + cell_at(mid, x + 1, cols)
          + cell_at(dn, x - 1, cols) + cell_at(dn, x, cols) + cell_at(dn, x + 1, cols);
        if (cell_at(mid, x, cols) == 1) begin
          if (n == int'(LIFE_STAY) || n == int'(LIFE_BIRTH))
            nxt[y][x] = 1'b1;
        end else if (n == int'(LIFE_BIRTH)) begin
          nxt[y][x] = 1'b1;
        end
      end
    end
    for (int y = 0; y < MAX_ROWS; y++)
      life_grid[y] = nxt[y];
  endfunction

  // expected result word for one accepted input word
  function automatic cell_result_t life_step(cell_word_t w);
    cell_result_t res;
    res = '0;
    if (w.act == ACT_ADVANCE) begin
      life_generation();
      return res;
    end
    if (int'(w.x) >= active_cols() || int'(w.y) >= active_rows()) begin
      res.flag = 1'b1;
      return res;
    end
    if (w.act == ACT_SET)
      life_grid[w.y][w.x] = 1'b1;
    res.alive = life_grid[w.y][w.x];
    return res;
  endfunction

  task automatic note_mismatch(string field, int want, int got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
  endtask

  // compare output words, then predict for the accepted input word
  always @(posedge clk) begin : check_cells
    cell_result_t want;
    cell_word_t   w;
    if (rst) begin
      in_fire = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected word: alive %0b status %0b", cell_alive, status);
        end else begin
          want = expected_cells.pop_front();
          if (cell_alive !== want.alive)
            note_mismatch("cell_alive", want.alive, cell_alive);
          if (status !== want.flag)
            note_mismatch("status", want.flag, status);
        end
      end
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        w.act = action;
        w.x = cell_x;
        w.y = cell_y;
        expected_cells.push_back(life_step(w));
      end
    end
  end

  // input driver and output stall, both on the falling edge
  always @(negedge clk) begin : drive_words
    cell_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          action <= w.act;
          cell_x <= w.x;
          cell_y <= w.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic push_word(logic [ACT_W-1:0] act, int x, int y);
    cell_word_t w;
    w.act = act;
    w.x = X_W'(x);
    w.y = Y_W'(y);
    pending_words.push_back(w);
  endtask

  // wait until the engine has nothing in flight
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_cells.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {26'($urandom), 6'(value)};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_COLS)
      grid_cols = CFG_W'(value);
    else
      grid_rows = CFG_W'(value);
  endtask

  task automatic set_grid_size(int cols, int rows);
    wait_idle();
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
  endtask

  // seed a small window, then advance a few generations and read around it
  task automatic queue_colony_run(int n);
    int cols;
    int rows;
    int added;
    int ww;
    int wh;
    int wx;
    int wy;
    int k;
    int x;
    int y;
    cols = active_cols();
    rows = active_rows();
    added = 0;
    while (added < n) begin
      if ($urandom_range(99) < 10) begin
        // noise word: any action, any coordinate
        push_word(ACT_W'($urandom_range(3)), int'($urandom_range(31)),
                  int'($urandom_range(31)));
        added++;
      end else begin
        ww = (cols < 6) ? cols : 6;
        wh = (rows < 6) ? rows : 6;
        wx = int'($urandom_range(cols - ww));
        wy = int'($urandom_range(rows - wh));
        k = int'($urandom_range(3, 12));
        repeat (k)
          push_word(ACT_SET, wx + int'($urandom_range(ww - 1)),
                    wy + int'($urandom_range(wh - 1)));
        added += k;
        repeat ($urandom_range(1, 4)) begin
          push_word(ACT_ADVANCE, int'($urandom_range(31)), int'($urandom_range(31)));
          added++;
          repeat ($urandom_range(2, 6)) begin
            x = int'($urandom_range(ww + 1)) + wx - 1;
            y = int'($urandom_range(wh + 1)) + wy - 1;
            x = (x < 0) ? 0 : ((x >= cols) ? cols - 1 : x);
            y = (y < 0) ? 0 : ((y >= rows) ? rows - 1 : y);
            push_word(($urandom_range(9) == 0) ? ACT_SPARE : ACT_READ, x, y);
            added++;
          end
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    action = '0;
    cell_x = '0;
    cell_y = '0;
    out_stall = 1'b0;
    in_fire = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    grid_cols = COLS_RESET;
    grid_rows = ROWS_RESET;
    for (int y = 0; y < MAX_ROWS; y++)
      life_grid[y] = '0;
    send_idle = 7;
    recv_idle = 86;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // corners, out-of-grid coordinates, spare code, lone cells dying, a blinker
    push_word(ACT_SET, 0, 0);
    push_word(ACT_SET, 29, 29);
    push_word(ACT_SET, 31, 31);
    push_word(ACT_SET, 30, 0);
    push_word(ACT_SET, 0, 30);
    push_word(ACT_READ, 0, 0);
    push_word(ACT_SPARE, 29, 29);
    push_word(ACT_READ, 1, 1);
    push_word(ACT_READ, 31, 0);
    push_word(ACT_SPARE, 31, 31);
    push_word(ACT_SET, 5, 4);
    push_word(ACT_SET, 5, 5);
    push_word(ACT_SET, 5, 6);
    push_word(ACT_ADVANCE, 31, 31);
    push_word(ACT_READ, 4, 5);
    push_word(ACT_READ, 5, 5);
    push_word(ACT_READ, 6, 5);
    push_word(ACT_READ, 5, 4);
    push_word(ACT_READ, 0, 0);
    push_word(ACT_READ, 29, 29);
    push_word(ACT_ADVANCE, 0, 0);
    push_word(ACT_READ, 5, 4);

    // empty grid: zero columns, then zero rows with an advance that clears
    set_grid_size(0, 30);
    push_word(ACT_SET, 0, 0);
    push_word(ACT_READ, 5, 5);
    set_grid_size(30, 0);
    push_word(ACT_SET, 1, 1);
    push_word(ACT_SPARE, 5, 4);
    push_word(ACT_ADVANCE, 0, 0);

    // register values above the grid bounds
    set_grid_size(63, 63);
    queue_colony_run(150);

    set_grid_size(1, 32);
    send_idle = 86;
    recv_idle = 7;
    queue_colony_run(100);

    set_grid_size(7, 5);
    queue_colony_run(300);

    set_grid_size(32, 1);
    send_idle = 0;
    recv_idle = 0;
    queue_colony_run(100);

    set_grid_size(12, 10);
    queue_colony_run(230);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_cells.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
